[src/mbse_pkg.sv]
package mbse_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned DurW  = 16;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [DurW-1:0] DotOnReset     = 16'd500;
  localparam logic [DurW-1:0] DashOnReset    = 16'd1500;
  localparam logic [DurW-1:0] ElemGapReset   = 16'd500;
  localparam logic [DurW-1:0] LetterGapReset = 16'd1500;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DOT_ON     = 8'd0,
    REG_DASH_ON    = 8'd1,
    REG_ELEM_GAP   = 8'd2,
    REG_LETTER_GAP = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DurW-1:0] dot_on;
    logic [DurW-1:0] dash_on;
    logic [DurW-1:0] elem_gap;
    logic [DurW-1:0] letter_gap;
  } cfg_t;

  // len is the element count, dash bit i set when element i is a dash
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] dash;
  } code_t;

  localparam logic [CharW-1:0] CharLowA = 8'h61;
  localparam logic [CharW-1:0] CharLowZ = 8'h7a;

  function automatic code_t morse_lookup(input logic [CharW-1:0] ch);
    code_t c;
    logic [CharW-1:0] off;
    c = '0;
    off = ch - CharLowA;
    if (ch >= CharLowA && ch <= CharLowZ) begin
      unique case (off[4:0])
        5'd0:  c = '{len: 3'd2, dash: 4'b0010};
        5'd1:  c = '{len: 3'd4, dash: 4'b0001};
        5'd2:  c = '{len: 3'd4, dash: 4'b0101};
        5'd3:  c = '{len: 3'd3, dash: 4'b0001};
        5'd4:  c = '{len: 3'd1, dash: 4'b0000};
        5'd5:  c = '{len: 3'd4, dash: 4'b0100};
        5'd6:  c = '{len: 3'd3, dash: 4'b0011};
        5'd7:  c = '{len: 3'd4, dash: 4'b0000};
        5'd8:  c = '{len: 3'd2, dash: 4'b0000};
        5'd9:  c = '{len: 3'd4, dash: 4'b1110};
        5'd10: c = '{len: 3'd3, dash: 4'b0101};
        5'd11: c = '{len: 3'd4, dash: 4'b0010};
        5'd12: c = '{len: 3'd2, dash: 4'b0011};
        5'd13: c = '{len: 3'd2, dash: 4'b0001};
        5'd14: c = '{len: 3'd3, dash: 4'b0111};
        5'd15: c = '{len: 3'd4, dash: 4'b0110};
        5'd16: c = '{len: 3'd4, dash: 4'b1011};
        5'd17: c = '{len: 3'd3, dash: 4'b0010};
        5'd18: c = '{len: 3'd3, dash: 4'b0000};
        5'd19: c = '{len: 3'd1, dash: 4'b0001};
        5'd20: c = '{len: 3'd3, dash: 4'b0100};
        5'd21: c = '{len: 3'd4, dash: 4'b1000};
        5'd22: c = '{len: 3'd3, dash: 4'b0110};
        5'd23: c = '{len: 3'd4, dash: 4'b1001};
        5'd24: c = '{len: 3'd4, dash: 4'b1101};
        5'd25: c = '{len: 3'd4, dash: 4'b0011};
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

[src/mbse_front.sv]
module mbse_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mbse_pkg::CharW-1:0] char_code_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output mbse_pkg::code_t           q_data_o
);
  import mbse_pkg::*;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  // anything outside a to z classifies as an empty code
  assign q_data_o   = morse_lookup(char_code_i);

endmodule

[src/mbse_queue.sv]
module mbse_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mbse_pkg::code_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mbse_pkg::code_t head_o
);
  import mbse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  code_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/mbse_back.sv]
module mbse_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mbse_pkg::cfg_t             cfg_i,
  input  logic                       q_empty_i,
  input  mbse_pkg::code_t            q_head_i,
  output logic                       q_pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       lamp_on_o,
  output logic [mbse_pkg::DurW-1:0]  duration_o,
  output logic                       last_segment_o
);
  import mbse_pkg::*;

  logic            busy_q, busy_d;
  code_t           code_q, code_d;
  logic [3:0]      seg_q, seg_d;
  logic            out_valid_q, out_valid_d;
  logic            lamp_q, lamp_d;
  logic [DurW-1:0] dur_q, dur_d;
  logic            last_q, last_d;

  code_t           cur;
  logic [3:0]      idx;
  logic            have_src, advance, is_last;

  // output register free, or being drained this cycle
  assign advance  = !out_valid_q || out_ready_i;
  assign have_src = busy_q || !q_empty_i;
  assign cur      = busy_q ? code_q : q_head_i;
  assign idx      = busy_q ? seg_q : 4'd0;
  assign is_last  = (idx == {cur.len, 1'b0});
  assign q_pop_o  = advance && !busy_q && !q_empty_i;

  always_comb begin
    busy_d      = busy_q;
    code_d      = code_q;
    seg_d       = seg_q;
    out_valid_d = out_valid_q;
    lamp_d      = lamp_q;
    dur_d       = dur_q;
    last_d      = last_q;
    if (advance) begin
      out_valid_d = have_src;
      if (have_src) begin
        priority if (is_last) begin
          lamp_d = 1'b0;
          dur_d  = cfg_i.letter_gap;
          last_d = 1'b1;
        end else if (!idx[0]) begin
          lamp_d = 1'b1;
          dur_d  = cur.dash[idx[2:1]] ? cfg_i.dash_on : cfg_i.dot_on;
          last_d = 1'b0;
        end else begin
          lamp_d = 1'b0;
          dur_d  = cfg_i.elem_gap;
          last_d = 1'b0;
        end
        busy_d = !is_last;
        code_d = cur;
        seg_d  = idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    seg_q  <= seg_d;
    lamp_q <= lamp_d;
    dur_q  <= dur_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign lamp_on_o      = lamp_q;
  assign duration_o     = dur_q;
  assign last_segment_o = last_q;

endmodule

[src/morse_blink_segment_encoder_top.sv]
// morse blink segment encoder
// input channel: in_valid_i / in_ready_o carry one beat per ASCII byte on
// char_code_i. lowercase a to z become dots and dashes, any other byte is an
// empty code. output channel: out_valid_o / out_ready_i carry one beat per
// lamp segment (lamp_on_o, duration_o, last_segment_o). a letter of n
// elements gives 2n+1 segments, an on and a gap per element, then the letter
// gap, which alone has last_segment_o set.
// the first segment of a byte goes into the queue at the accepting edge and
// then into the output register, once the sequencer is free and not stalled.
// a byte gives 1 to 9 segments (2n+1), set by the back-end sequencer that
// puts out one segment per cycle while out_ready_i does not stall it; bytes
// of one segment stream at one per cycle under the same condition.
// a small queue sits between the classifier and the sequencer, so bytes are
// still taken while segments wait; when it fills, in_ready_o drops.
// a stall on out_ready_i holds the output register and the sequencer.
// reset empties the queue and the output register and loads the timing
// registers with 500, 1500, 500, 1500 ticks. the user must write the timing
// registers through cfg_we_i / cfg_idx_i / cfg_wdata_i only while the block
// is idle; the block itself does not enforce this. indexes above 3 are ignored.
module morse_blink_segment_encoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbse_pkg::DurW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mbse_pkg::CharW-1:0]    char_code_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          lamp_on_o,
  output logic [mbse_pkg::DurW-1:0]     duration_o,
  output logic                          last_segment_o
);
  import mbse_pkg::*;

  cfg_t  cfg_q;
  code_t push_data, head;
  logic  push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_on     <= DotOnReset;
      cfg_q.dash_on    <= DashOnReset;
      cfg_q.elem_gap   <= ElemGapReset;
      cfg_q.letter_gap <= LetterGapReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DOT_ON:     cfg_q.dot_on     <= cfg_wdata_i;
        REG_DASH_ON:    cfg_q.dash_on    <= cfg_wdata_i;
        REG_ELEM_GAP:   cfg_q.elem_gap   <= cfg_wdata_i;
        REG_LETTER_GAP: cfg_q.letter_gap <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mbse_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_data_o    (push_data)
  );

  mbse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  mbse_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_empty_i      (empty),
    .q_head_i       (head),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .lamp_on_o      (lamp_on_o),
    .duration_o     (duration_o),
    .last_segment_o (last_segment_o)
  );

endmodule
